### rtl/mpq_pkg.sv
package mpq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [OCC_W-1:0]         occ_t;

    // controller to datapath
    typedef struct packed {
        logic capture;     // take the request beat into the item registers
        logic exec;        // latch overflow / empty flags for this item
        logic enq;         // append the item at the tail
        logic scan_start;  // reset scan index and running minimum
        logic scan_rd;     // one scan step
        logic shift_start; // point the compaction just past the winner
        logic shift_step;  // one compaction step
        logic deq_done;    // drop one entry from the count
        logic res_load;    // load the response register
    } mpq_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic req_valid;
        logic is_deq;
        logic full;
        logic empty;
        logic scan_end;   // every held entry read and compared
        logic shift_end;  // every later entry moved down
        logic rsp_free;   // response register can take a beat
    } mpq_stat_t;

endpackage

### rtl/mpq_req_if.sv
interface mpq_req_if;

    logic                valid;
    logic                ready;
    logic                cmd;
    mpq_pkg::word_t      key_in;
    mpq_pkg::word_t      priority_in;

    modport source (output valid, output cmd, output key_in, output priority_in, input ready);
    modport sink   (input valid, input cmd, input key_in, input priority_in, output ready);

endinterface

### rtl/mpq_rsp_if.sv
interface mpq_rsp_if;

    logic                valid;
    logic                ready;
    mpq_pkg::word_t      key_out;
    logic                was_empty;
    logic                overflow;
    mpq_pkg::occ_t       occupancy;

    modport source (output valid, output key_out, output was_empty, output overflow,
                    output occupancy, input ready);
    modport sink   (input valid, input key_out, input was_empty, input overflow,
                    input occupancy, output ready);

endinterface

### rtl/mpq_datapath.sv
module mpq_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  mpq_pkg::mpq_ctrl_t ctrl,
    output mpq_pkg::mpq_stat_t stat,
    input  logic               req_valid,
    input  logic               req_cmd,
    input  mpq_pkg::word_t     req_key,
    input  mpq_pkg::word_t     req_prio,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mpq_pkg::word_t     rsp_key,
    output logic               rsp_empty,
    output logic               rsp_ovf,
    output mpq_pkg::occ_t      rsp_occ
);

    // entry store: key in the upper half, priority in the lower half
    logic [2*mpq_pkg::DATA_W-1:0] mem [mpq_pkg::DEPTH];
    logic [2*mpq_pkg::DATA_W-1:0] rd_data_reg;

    logic           cmd_reg;
    mpq_pkg::word_t key_reg;
    mpq_pkg::word_t prio_reg;
    mpq_pkg::cnt_t  count_reg;
    mpq_pkg::cnt_t  rd_idx_reg;
    mpq_pkg::idx_t  cmp_idx_reg;
    logic           cmp_vld_reg;
    logic           first_reg;
    mpq_pkg::idx_t  best_idx_reg;
    mpq_pkg::word_t best_prio_reg;
    mpq_pkg::word_t best_key_reg;
    logic           wr_pend_reg;
    mpq_pkg::idx_t  wr_addr_reg;
    logic           ovf_reg;
    logic           emp_reg;
    logic           rsp_valid_reg;
    mpq_pkg::word_t rsp_key_reg;
    logic           rsp_empty_reg;
    logic           rsp_ovf_reg;
    mpq_pkg::occ_t  rsp_occ_reg;

    logic           full;
    logic           rd_more;
    mpq_pkg::word_t cur_prio;
    mpq_pkg::word_t cur_key;
    logic           take;

    assign full     = (count_reg == mpq_pkg::CNT_W'(mpq_pkg::DEPTH));
    assign rd_more  = (rd_idx_reg < count_reg);
    assign cur_key  = rd_data_reg[2*mpq_pkg::DATA_W-1:mpq_pkg::DATA_W];
    assign cur_prio = rd_data_reg[mpq_pkg::DATA_W-1:0];
    assign take     = cmp_vld_reg && (first_reg || (cur_prio < best_prio_reg));

    assign stat.req_valid = req_valid;
    assign stat.is_deq    = (cmd_reg == mpq_pkg::CMD_DEQ);
    assign stat.full      = full;
    assign stat.empty     = (count_reg == '0);
    assign stat.scan_end  = !rd_more && !cmp_vld_reg;
    assign stat.shift_end = !rd_more && !wr_pend_reg;
    assign stat.rsp_free  = !rsp_valid_reg || rsp_ready;

    // store write port and registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.enq)
        begin
            mem[count_reg[mpq_pkg::IDX_W-1:0]] <= {key_reg, prio_reg};
        end
        else if (ctrl.shift_step && wr_pend_reg)
        begin
            mem[wr_addr_reg] <= rd_data_reg;
        end
        if ((ctrl.scan_rd || ctrl.shift_step) && rd_more)
        begin
            rd_data_reg <= mem[rd_idx_reg[mpq_pkg::IDX_W-1:0]];
        end
    end

    // item and running minimum payload
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= req_cmd;
            key_reg  <= req_key;
            prio_reg <= req_prio;
        end
        if (ctrl.scan_rd && rd_more)
        begin
            cmp_idx_reg <= rd_idx_reg[mpq_pkg::IDX_W-1:0];
        end
        if (ctrl.scan_rd && take)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_prio_reg <= cur_prio;
            best_key_reg  <= cur_key;
        end
        if (ctrl.shift_step && rd_more)
        begin
            wr_addr_reg <= rd_idx_reg[mpq_pkg::IDX_W-1:0] - mpq_pkg::IDX_W'(1);
        end
        if (ctrl.res_load)
        begin
            rsp_key_reg   <= (stat.is_deq && !emp_reg) ? best_key_reg : '0;
            rsp_empty_reg <= emp_reg;
            rsp_ovf_reg   <= ovf_reg;
            rsp_occ_reg   <= mpq_pkg::OCC_W'(count_reg);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            first_reg     <= 1'b0;
            wr_pend_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            emp_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.exec)
            begin
                ovf_reg <= !stat.is_deq && full;
                emp_reg <= stat.is_deq && stat.empty;
            end
            if (ctrl.enq)
            begin
                count_reg <= count_reg + mpq_pkg::CNT_W'(1);
            end
            else if (ctrl.deq_done)
            begin
                count_reg <= count_reg - mpq_pkg::CNT_W'(1);
            end

            if (ctrl.scan_start)
            begin
                rd_idx_reg  <= '0;
                cmp_vld_reg <= 1'b0;
                first_reg   <= 1'b1;
            end
            else if (ctrl.scan_rd)
            begin
                cmp_vld_reg <= rd_more;
                if (rd_more)
                begin
                    rd_idx_reg <= rd_idx_reg + mpq_pkg::CNT_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    first_reg <= 1'b0;
                end
            end
            else if (ctrl.shift_start)
            begin
                rd_idx_reg  <= mpq_pkg::CNT_W'(best_idx_reg) + mpq_pkg::CNT_W'(1);
                wr_pend_reg <= 1'b0;
            end
            else if (ctrl.shift_step)
            begin
                wr_pend_reg <= rd_more;
                if (rd_more)
                begin
                    rd_idx_reg <= rd_idx_reg + mpq_pkg::CNT_W'(1);
                end
            end

            if (ctrl.res_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_key   = rsp_key_reg;
    assign rsp_empty = rsp_empty_reg;
    assign rsp_ovf   = rsp_ovf_reg;
    assign rsp_occ   = rsp_occ_reg;

endmodule

### rtl/mpq_ctrl.sv
module mpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  mpq_pkg::mpq_stat_t stat,
    output mpq_pkg::mpq_ctrl_t ctrl,
    output logic               req_ready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (stat.req_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctrl.exec = 1'b1;
                if (!stat.is_deq)
                begin
                    ctrl.enq   = !stat.full;
                    state_next = ST_FIN;
                end
                else if (stat.empty)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    ctrl.scan_start = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    ctrl.shift_start = 1'b1;
                    state_next       = ST_SHIFT;
                end
                else
                begin
                    ctrl.scan_rd = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                if (stat.shift_end)
                begin
                    ctrl.deq_done = 1'b1;
                    state_next    = ST_FIN;
                end
                else
                begin
                    ctrl.shift_step = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (stat.rsp_free)
                begin
                    ctrl.res_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/min_priority_queue_top.sv
// channel  modport  beat contents
// -------  -------  ------------------------------------------------
// req      sink     cmd (0 enqueue, 1 dequeue), key_in, priority_in
// rsp      source   key_out, was_empty, overflow, occupancy
//
// one request beat in, one response beat out, one item at a time
// enqueue: the item passes the execute and finish states; the response register is loaded in finish
// dequeue with n held entries: a scan reads and compares all n priorities, then
//   compaction moves each entry after the winner down one place, both through the
//   single read port of the entry store
// reset clears the entry count and control only; store contents need no clearing
// a waiting response does not block the next request beat; a stalled rsp only
//   holds the finished item before its result is loaded
module min_priority_queue_top (
    input logic clk,
    input logic rst_n,
    mpq_req_if.sink   req,
    mpq_rsp_if.source rsp
);

    mpq_pkg::mpq_ctrl_t ctrl;
    mpq_pkg::mpq_stat_t stat;

    // sequencer: idle, execute, scan for minimum, compact, respond
    mpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .ctrl      (ctrl),
        .req_ready (req.ready)
    );

    // entry store, running minimum, entry count and response register
    mpq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_key   (req.key_in),
        .req_prio  (req.priority_in),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_key   (rsp.key_out),
        .rsp_empty (rsp.was_empty),
        .rsp_ovf   (rsp.overflow),
        .rsp_occ   (rsp.occupancy)
    );

endmodule
